// ===== rtl/vics_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vics_pkg
// Shared constants and helpers for the velocity integrate / speed clamp block.
// ----------------------------------------------------------------------------
package vics_pkg;

    localparam int DATA_W   = 32;
    localparam int WIDE_W   = 64;
    localparam int SIDE_W   = 2 * DATA_W + 1;   // limited flag and both components
    localparam int PADDR_W  = 3;

    localparam logic [DATA_W-1:0] TIME_STEP_RST = 32'd6554;
    localparam logic [DATA_W-1:0] SPEED_CAP_RST = 32'd65536;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_TIME_STEP = 1'b0,
        REG_SPEED_CAP = 1'b1
    } reg_idx_t;

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31
    function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        begin
            r = v[DATA_W-1] ? (~DATA_W'(v) + DATA_W'(1)) : DATA_W'(v);
            return r;
        end
    endfunction

endpackage

// ===== rtl/vics_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vics_sqrt
// Pipelined integer square root, one root bit per stage, with a side payload.
// ----------------------------------------------------------------------------
module vics_sqrt #(
    parameter int SIDE_W = vics_pkg::SIDE_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [vics_pkg::WIDE_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [vics_pkg::DATA_W-1:0]  out_root,
    output logic [SIDE_W-1:0]            out_side
);
    import vics_pkg::*;

    localparam int NSTG = DATA_W;

    logic                vld_reg  [0:NSTG-1];
    logic [WIDE_W-1:0]   rem_reg  [0:NSTG-1];
    logic [DATA_W-1:0]   root_reg [0:NSTG-1];
    logic [SIDE_W-1:0]   side_reg [0:NSTG-1];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stg
            localparam int I = NSTG - 1 - k;
            logic              vld_in;
            logic [WIDE_W-1:0] rem_in;
            logic [DATA_W-1:0] root_in;
            logic [SIDE_W-1:0] side_in;
            logic [WIDE_W:0]   trial;
            logic              take;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign rem_in  = in_rad;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // trial = 2*root*2^I + 2^(2I)
            assign trial = ((WIDE_W+1)'(root_in) << (I + 1)) + ((WIDE_W+1)'(1) << (2 * I));
            assign take  = ({1'b0, rem_in} >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? WIDE_W'({1'b0, rem_in} - trial) : rem_in;
                    root_reg[k] <= take ? (root_in | (DATA_W'(1) << I)) : root_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NSTG-1];
    assign out_root  = root_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

// ===== rtl/vics_div2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vics_div2
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Quotient must fit 32 bits (numerator below divisor * 2^32).
// ----------------------------------------------------------------------------
module vics_div2 #(
    parameter int SIDE_W = vics_pkg::SIDE_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [vics_pkg::WIDE_W-1:0]  in_num_x,
    input  logic [vics_pkg::WIDE_W-1:0]  in_num_y,
    input  logic [vics_pkg::DATA_W-1:0]  in_den,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [vics_pkg::DATA_W-1:0]  out_quo_x,
    output logic [vics_pkg::DATA_W-1:0]  out_quo_y,
    output logic [SIDE_W-1:0]            out_side
);
    import vics_pkg::*;

    localparam int NSTG = DATA_W;

    logic                vld_reg  [0:NSTG-1];
    logic [WIDE_W-1:0]   remx_reg [0:NSTG-1];
    logic [WIDE_W-1:0]   remy_reg [0:NSTG-1];
    logic [DATA_W-1:0]   qx_reg   [0:NSTG-1];
    logic [DATA_W-1:0]   qy_reg   [0:NSTG-1];
    logic [DATA_W-1:0]   den_reg  [0:NSTG-1];
    logic [SIDE_W-1:0]   side_reg [0:NSTG-1];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stg
            localparam int I = NSTG - 1 - k;
            logic              vld_in;
            logic [WIDE_W-1:0] remx_in;
            logic [WIDE_W-1:0] remy_in;
            logic [DATA_W-1:0] qx_in;
            logic [DATA_W-1:0] qy_in;
            logic [DATA_W-1:0] den_in;
            logic [SIDE_W-1:0] side_in;
            logic [WIDE_W-1:0] dsh;
            logic              takex;
            logic              takey;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign remx_in = in_num_x;
                assign remy_in = in_num_y;
                assign qx_in   = '0;
                assign qy_in   = '0;
                assign den_in  = in_den;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign remx_in = remx_reg[k-1];
                assign remy_in = remy_reg[k-1];
                assign qx_in   = qx_reg[k-1];
                assign qy_in   = qy_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign dsh   = WIDE_W'(den_in) << I;
            assign takex = (remx_in >= dsh);
            assign takey = (remy_in >= dsh);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    remx_reg[k] <= takex ? (remx_in - dsh) : remx_in;
                    remy_reg[k] <= takey ? (remy_in - dsh) : remy_in;
                    qx_reg[k]   <= takex ? (qx_in | (DATA_W'(1) << I)) : qx_in;
                    qy_reg[k]   <= takey ? (qy_in | (DATA_W'(1) << I)) : qy_in;
                    den_reg[k]  <= den_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NSTG-1];
    assign out_quo_x = qx_reg[NSTG-1];
    assign out_quo_y = qy_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

// ===== rtl/velocity_integrate_speed_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_integrate_speed_clamp
// Euler velocity update with saturation and a cap on the speed magnitude.
// ----------------------------------------------------------------------------
// One agent per transfer, one result per agent, a new agent accepted every
// cycle. From input transfer to output valid an agent passes the force step
// and squared speed stages (1 to 4), the square root (one root bit per
// stage), the scale products (stage 5), the two dividers (one quotient bit
// per stage) and the output register. The whole pipeline advances together;
// it stalls only while the output register holds a result that is not
// taken. time_step and speed_cap are read live, so write them only while
// the pipeline is empty.
module velocity_integrate_speed_clamp (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vics_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [127:0]                   s_axis_tdata,   // vel_x, vel_y, force_x, force_y
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [63:0]                    m_axis_tdata,   // new_vel_x, new_vel_y
    output logic                           m_axis_tuser    // speed_limited
);
    import vics_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DATA_W-1:0] time_step_reg;
    logic [DATA_W-1:0] speed_cap_reg;
    reg_idx_t          cfg_idx;

    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RST;
            speed_cap_reg <= SPEED_CAP_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_idx)
                REG_TIME_STEP: time_step_reg <= pwdata;
                REG_SPEED_CAP: speed_cap_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TIME_STEP: prdata = time_step_reg;
            REG_SPEED_CAP: prdata = speed_cap_reg;
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic en;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // force step: v + floor(f * dt / 2^16), saturated
    function automatic logic [DATA_W-1:0] force_add(input logic [DATA_W-1:0] v,
                                                    input logic [WIDE_W-1:0] p,
                                                    input logic neg);
        logic [WIDE_W-1:0]  pr;
        logic [47:0]        d;
        logic signed [49:0] sum;
        logic [DATA_W-1:0]  r;
        begin
            pr  = neg ? (p + WIDE_W'(65535)) : p;
            d   = pr[63:16];
            sum = 50'(signed'(v)) + (neg ? -50'(signed'({2'b00, d})) : 50'(signed'({2'b00, d})));
            if (sum > 50'sd2147483647)
                r = 32'h7FFF_FFFF;
            else if (sum < -50'sd2147483648)
                r = 32'h8000_0000;
            else
                r = sum[31:0];
            return r;
        end
    endfunction

    // ---------------- stage 1: force times time step ----------------
    logic              v1_reg;
    logic [DATA_W-1:0] vx1_reg, vy1_reg;
    logic              fnx1_reg, fny1_reg;
    logic [WIDE_W-1:0] px1_reg, py1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx1_reg  <= s_axis_tdata[31:0];
            vy1_reg  <= s_axis_tdata[63:32];
            fnx1_reg <= s_axis_tdata[95];
            fny1_reg <= s_axis_tdata[127];
            px1_reg  <= WIDE_W'(abs32(s_axis_tdata[95:64])) * WIDE_W'(time_step_reg);
            py1_reg  <= WIDE_W'(abs32(s_axis_tdata[127:96])) * WIDE_W'(time_step_reg);
        end
    end

    // ---------------- stage 2: add and saturate ----------------
    logic              v2_reg;
    logic [DATA_W-1:0] vx2_reg, vy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx2_reg <= force_add(vx1_reg, px1_reg, fnx1_reg);
            vy2_reg <= force_add(vy1_reg, py1_reg, fny1_reg);
        end
    end

    // ---------------- stage 3: squares ----------------
    logic              v3_reg;
    logic [DATA_W-1:0] vx3_reg, vy3_reg;
    logic [WIDE_W-1:0] sqx3_reg, sqy3_reg, capsq3_reg;
    logic [DATA_W-1:0] ax2, ay2;

    assign ax2 = abs32(vx2_reg);
    assign ay2 = abs32(vy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx3_reg    <= vx2_reg;
            vy3_reg    <= vy2_reg;
            sqx3_reg   <= WIDE_W'(ax2) * WIDE_W'(ax2);
            sqy3_reg   <= WIDE_W'(ay2) * WIDE_W'(ay2);
            capsq3_reg <= WIDE_W'(speed_cap_reg) * WIDE_W'(speed_cap_reg);
        end
    end

    // ---------------- stage 4: sum and cap test ----------------
    logic              v4_reg;
    logic              lim4_reg;
    logic [WIDE_W-1:0] sq4_reg;
    logic [DATA_W-1:0] vx4_reg, vy4_reg;
    logic [WIDE_W-1:0] sq3;

    assign sq3 = sqx3_reg + sqy3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq4_reg  <= sq3;
            lim4_reg <= (sq3 > capsq3_reg);
            vx4_reg  <= vx3_reg;
            vy4_reg  <= vy3_reg;
        end
    end

    // ---------------- square root ----------------
    logic              sq_valid;
    logic [DATA_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    vics_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rad    (sq4_reg),
        .in_side   ({lim4_reg, vy4_reg, vx4_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- stage 5: scale products ----------------
    logic              v5_reg;
    logic [WIDE_W-1:0] nx5_reg, ny5_reg;
    logic [DATA_W-1:0] s5_reg;
    logic [SIDE_W-1:0] side5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg   <= WIDE_W'(abs32(sq_side[DATA_W-1:0])) * WIDE_W'(speed_cap_reg);
            ny5_reg   <= WIDE_W'(abs32(sq_side[2*DATA_W-1:DATA_W])) * WIDE_W'(speed_cap_reg);
            s5_reg    <= (sq_root == '0) ? DATA_W'(1) : sq_root;
            side5_reg <= sq_side;
        end
    end

    // ---------------- division ----------------
    logic              dv_valid;
    logic [DATA_W-1:0] qx, qy;
    logic [SIDE_W-1:0] dv_side;

    vics_div2 #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num_x  (nx5_reg),
        .in_num_y  (ny5_reg),
        .in_den    (s5_reg),
        .in_side   (side5_reg),
        .out_valid (dv_valid),
        .out_quo_x (qx),
        .out_quo_y (qy),
        .out_side  (dv_side)
    );

    // ---------------- output register ----------------
    logic [DATA_W-1:0] ox_reg, oy_reg;
    logic              olim_reg;
    logic              dv_lim;
    logic [DATA_W-1:0] dv_vx, dv_vy;

    assign dv_lim = dv_side[2*DATA_W];
    assign dv_vx  = dv_side[DATA_W-1:0];
    assign dv_vy  = dv_side[2*DATA_W-1:DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            olim_reg <= dv_lim;
            ox_reg   <= !dv_lim ? dv_vx : (dv_vx[DATA_W-1] ? (~qx + DATA_W'(1)) : qx);
            oy_reg   <= !dv_lim ? dv_vy : (dv_vy[DATA_W-1] ? (~qy + DATA_W'(1)) : qy);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {oy_reg, ox_reg};
    assign m_axis_tuser  = olim_reg;

    // ---------------- assertions ----------------
    // a limited item always has a root at or above the cap
    a_root_ge_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && side5_reg[2*DATA_W]) |-> (s5_reg >= speed_cap_reg))
        else $error("root below cap on a limited item");

    // neither scaled component of a limited item exceeds the cap
    a_quo_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && dv_lim) |-> (qx <= speed_cap_reg && qy <= speed_cap_reg))
        else $error("quotient above cap");

    // a limited item never has a zero square sum
    a_lim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && lim4_reg) |-> (sq4_reg != '0))
        else $error("limited flag on zero speed");

    // a stalled output stage keeps its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(ox_reg)
            && $stable(oy_reg) && $stable(olim_reg)))
        else $error("output changed while stalled");

endmodule

// ===== bench/tb_velocity_integrate_speed_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_velocity_integrate_speed_clamp
// Self-checking bench for the velocity integrate / speed clamp block.
// ----------------------------------------------------------------------------
// A queue of agents feeds a stream driver; a monitor compares every output
// transfer against a velocity predictor. Phases run with different time
// step and speed cap settings, written over the register port while idle.
// Both stream sides stall at random, with one stretch at full rate.
module tb_velocity_integrate_speed_clamp;
    import vics_pkg::*;

    localparam int LATENCY   = 70;
    localparam int CYCLE_MAX = 400000;

    typedef struct packed
    {
        logic signed [31:0] fy;
        logic signed [31:0] fx;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
    } agent_t;

    typedef struct
    {
        logic [31:0] nvx;
        logic [31:0] nvy;
        logic        limited;
    } vel_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    agent_t      agent_q[$];
    vel_t        vel_expected_q[$];
    logic [31:0] dt_cfg = TIME_STEP_RST;
    logic [31:0] cap_cfg = SPEED_CAP_RST;
    int          errors = 0;
    int          checked = 0;
    int          limited_seen = 0;
    int          cycles = 0;
    bit          no_stall = 1'b0;
    bit          hold_off = 1'b0;
    bit          in_taken = 1'b0;

    velocity_integrate_speed_clamp DUT (.*);

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Force step: exact product, floor shift, saturating add
    function automatic logic signed [63:0] step_vel(logic signed [31:0] v,
                                                   logic signed [31:0] f);
        logic signed [95:0] p;
        logic signed [63:0] r;
        p = $signed({{32{f[31]}}, f}) * $signed({32'd0, dt_cfg});
        r = 64'(v) + 64'(p >>> 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] shrink(logic signed [63:0] v, logic [63:0] s);
        logic [63:0] m;
        logic [63:0] q;
        m = v < 0 ? 64'(-v) : 64'(v);
        q = (m * 64'(cap_cfg)) / s;
        return v < 0 ? 32'(-q) : 32'(q);
    endfunction

    function automatic vel_t predict_velocity(agent_t a);
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] sq;
        logic [63:0] s;
        vel_t r;
        vx = step_vel(a.vx, a.fx);
        vy = step_vel(a.vy, a.fy);
        ax = vx < 0 ? 64'(-vx) : 64'(vx);
        ay = vy < 0 ? 64'(-vy) : 64'(vy);
        sq = ax * ax + ay * ay;
        r.limited = sq > 64'(cap_cfg) * 64'(cap_cfg);
        if (r.limited)
        begin
            s = root64(sq);
            if (s == 0) s = 1;
            r.nvx = shrink(vx, s);
            r.nvy = shrink(vy, s);
        end
        else
        begin
            r.nvx = vx[31:0];
            r.nvy = vy[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
        errors++;
    endtask

    // Input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (agent_q.size() > 0 && !hold_off &&
                    (no_stall || $urandom_range(99) >= 22))
                begin
                    s_axis_tdata  <= agent_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= no_stall || $urandom_range(99) >= 22;
        end
    end

    // Predict on accepted input, check on accepted output
    always @(posedge clk)
    begin
        vel_t w;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            vel_expected_q.push_back(predict_velocity(agent_t'(s_axis_tdata)));
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (vel_expected_q.size() == 0)
            begin
                $display("unexpected output transfer %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                w = vel_expected_q.pop_front();
                if (m_axis_tdata[31:0] !== w.nvx)
                    report_mismatch("new_vel_x", m_axis_tdata[31:0], w.nvx);
                if (m_axis_tdata[63:32] !== w.nvy)
                    report_mismatch("new_vel_y", m_axis_tdata[63:32], w.nvy);
                if (m_axis_tuser !== w.limited)
                    report_mismatch("speed_limited", 32'(m_axis_tuser), 32'(w.limited));
                if (w.limited) limited_seen++;
            end
            checked++;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TIME_STEP) dt_cfg = value;
        else cap_cfg = value;
    endtask

    task automatic drain_all();
        while (agent_q.size() > 0 || vel_expected_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            1: return 32'($signed(16'($urandom)));
            2: return 32'($signed(24'($urandom)));
            3: return $urandom_range(1) ? 32'h0 : 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int n);
        agent_t a;
        repeat (n)
        begin
            a.vx = rand_word();
            a.vy = rand_word();
            a.fx = rand_word();
            a.fy = rand_word();
            agent_q.push_back(a);
        end
    endtask

    task automatic queue_agent(logic [31:0] vx, logic [31:0] vy,
                               logic [31:0] fx, logic [31:0] fy);
        agent_t a;
        a.vx = vx; a.vy = vy; a.fx = fx; a.fy = fy;
        agent_q.push_back(a);
    endtask

    initial
    begin
        logic [31:0] dts[6];
        logic [31:0] caps[6];
        dts  = '{32'd0, 32'hffffffff, 32'd65536, 32'd6554, 32'd1, 32'h00400000};
        caps = '{32'd0, 32'hffffffff, 32'd65536, 32'h00200000, 32'd3, 32'h7fffffff};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, extremes, zero velocity, speed at the cap
        queue_agent(0, 0, 0, 0);
        queue_agent(32'd65536, 0, 0, 0);
        queue_agent(0, 32'hffff0000, 0, 0);
        queue_agent(32'd65537, 0, 0, 0);
        queue_agent(32'd39321, 32'd52429, 0, 0);
        queue_agent(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_agent(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_agent(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h1);
        queue_agent(0, 0, 32'hffffffff, 32'hfffffff0);
        drain_all();
        reg_write(REG_SPEED_CAP, 0);
        queue_agent(0, 0, 0, 0);
        queue_agent(1, 0, 0, 0);
        queue_agent(32'hffffffff, 32'h12345, 0, 0);
        drain_all();
        reg_write(REG_TIME_STEP, 32'hffffffff);
        reg_write(REG_SPEED_CAP, 32'hffffffff);
        queue_agent(32'h7fff0000, 32'h80010000, 32'h7fffffff, 32'h80000000);
        queue_agent(0, 0, 32'h80000000, 32'h7fffffff);
        queue_agent(32'h40000000, 32'h40000000, 32'd5, 32'hfffffffb);
        drain_all();
        // Hold the sender off while the cap is written and the next agent queued
        hold_off = 1'b1;
        reg_write(REG_SPEED_CAP, 32'd65536);
        queue_agent(32'd65536, 32'd1, 0, 0);
        hold_off = 1'b0;
        drain_all();

        // Random phases across settings
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_TIME_STEP, ph < 5 ? dts[ph] : $urandom);
            reg_write(REG_SPEED_CAP, caps[(ph + 3) % 6]);
            no_stall = (ph == 2);
            queue_random(200);
            drain_all();
        end
        no_stall = 1'b0;

        $display("checked %0d results over several time step and cap settings,", checked);
        $display("%0d of them speed limited", limited_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/vics_pkg.sv
rtl/vics_sqrt.sv
rtl/vics_div2.sv
rtl/velocity_integrate_speed_clamp.sv
bench/tb_velocity_integrate_speed_clamp.sv
